// File: rtl/id_registry_free_list_unit_defines.svh
// assertion helpers shared by the registry rtl

`ifndef ID_REGISTRY_FREE_LIST_UNIT_DEFINES_SVH
`define ID_REGISTRY_FREE_LIST_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define IDRFL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define IDRFL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/idrfl_pkg.sv
package idrfl_pkg;

    // default sizing
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int FREE_DEPTH_DEF  = 64;
    localparam int GROW_STEP_DEF   = 100;
    localparam int HANDLE_BITS_DEF = 32;

    // register values after reset
    localparam int RST_ENTRY_LIMIT    = 1024;
    localparam int RST_FREE_LIST_SIZE = 64;
    localparam int RST_START_SIZE     = 128;

    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_REGISTER      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE_ID     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE_HANDLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR         = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_LIST_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SIZE     = 2'd2;

endpackage

// File: rtl/idrfl_ram.sv
module idrfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/id_registry_free_list_unit.sv
// handle registry: a handle registered with mode 0 gets a nonzero id popped from a free-id
// stack; when the stack is empty the slot table is scanned from id 1 up for empty slots
// (refilling the stack), and failing that the table grows by GROW_STEP slots up to the
// entry_limit register. mode 1 removes by id, mode 2 removes by handle (first match from
// id 1 up), mode 3 empties table and stack. every word in gives one word out unless a
// start_size write cuts it short; assigned_id 0 with ok 0 flags failure. slot table and
// stack live in two synchronous rams, and the slot ram's single read port sets the pace:
// one slot per cycle. one word is worked on at a time; s_tready is high only while idle,
// and a finished result may wait in the output register while the next word is taken.
// after reset and after each write of start_size the block runs a clearing pass over all
// MAX_ENTRIES slots of the slot ram with s_tready low; configuration writes are taken at
// any time (cfg_ready is always high).
`include "id_registry_free_list_unit_defines.svh"

module id_registry_free_list_unit
    import idrfl_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int FREE_DEPTH  = FREE_DEPTH_DEF,
    parameter int GROW_STEP   = GROW_STEP_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    localparam int ID_W       = $clog2(MAX_ENTRIES),
    localparam int SIZE_W     = ID_W + 1,
    localparam int FSZ_W      = $clog2(FREE_DEPTH) + 1,
    localparam int CFG_W      = (SIZE_W > FSZ_W) ? SIZE_W : FSZ_W,
    localparam int S_TDATA_W  = ((HANDLE_BITS + ID_W + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((ID_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // handle, entry_id, zero fill
    input  logic [MODE_W-1:0]    s_tuser,   // mode

    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // assigned_id, zero fill
    output logic                 m_tuser,   // ok

    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
    localparam int FIDX_W = $clog2(FREE_DEPTH);
    localparam int GS_W   = $clog2(GROW_STEP + 1);
    localparam int SUM_W  = ((SIZE_W > GS_W) ? SIZE_W : GS_W) + 1;
    localparam int USED_RST = (RST_START_SIZE > MAX_ENTRIES) ? MAX_ENTRIES : RST_START_SIZE;
    localparam int LIM_MIN  = 2;
    localparam int FSZ_MIN  = 2;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] ST_SWEEP    = 4'd1;
    localparam logic [ST_W-1:0] ST_SCAN     = 4'd2;
    localparam logic [ST_W-1:0] ST_GROW_CHK = 4'd3;
    localparam logic [ST_W-1:0] ST_GROW     = 4'd4;
    localparam logic [ST_W-1:0] ST_POP_RD   = 4'd5;
    localparam logic [ST_W-1:0] ST_POP_WR   = 4'd6;
    localparam logic [ST_W-1:0] ST_RID_CHK  = 4'd7;
    localparam logic [ST_W-1:0] ST_FIND     = 4'd8;
    localparam logic [ST_W-1:0] ST_RESP     = 4'd9;

    // control state
    logic [ST_W-1:0]        state_reg, state_next;
    logic [SIZE_W-1:0]      lim_cfg_reg, lim_cfg_next;     // entry_limit as written
    logic [FSZ_W-1:0]       fsz_cfg_reg, fsz_cfg_next;     // free_list_size as written
    logic [SIZE_W-1:0]      used_reg, used_next;           // slots in use
    logic [CNT_W-1:0]       fc_reg, fc_next;               // ids on the free stack
    logic [SIZE_W-1:0]      addr_reg, addr_next;           // sweep / scan / grow pointer
    logic [SIZE_W-1:0]      end_reg, end_next;             // sweep or grow bound
    logic                   rd_vld_reg, rd_vld_next;       // slot read in flight
    logic                   sweep_item_reg, sweep_item_next;
    logic                   m_valid_reg, m_valid_next;

    // payload
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [ID_W-1:0]        eid_reg, eid_next;
    logic [ID_W-1:0]        rd_addr_reg, rd_addr_next;     // slot id of the data coming back
    logic [ID_W-1:0]        res_id_reg, res_id_next;
    logic                   res_ok_reg, res_ok_next;
    logic [ID_W-1:0]        m_id_reg, m_id_next;
    logic                   m_ok_reg, m_ok_next;

    // ram ports
    logic                   slot_we;
    logic [ID_W-1:0]        slot_waddr, slot_raddr;
    logic [HANDLE_BITS-1:0] slot_wdata, slot_rdata;
    logic                   stk_we;
    logic [FIDX_W-1:0]      stk_waddr, stk_raddr;
    logic [ID_W-1:0]        stk_wdata, stk_rdata;

    // derived values
    logic [SIZE_W-1:0]      lim;
    logic [FSZ_W-1:0]       fs;
    logic [SIZE_W-1:0]      start_val;
    logic [SUM_W-1:0]       grow_sum;
    logic [SIZE_W-1:0]      grow_end;
    logic [CNT_W-1:0]       fc_dec;
    logic [CNT_W:0]         fc_inc1;
    logic                   push_room;
    logic [SIZE_W-1:0]      addr_inc;
    logic                   s_accept;
    logic                   cfg_wr;
    logic                   cfg_start_wr;
    logic                   issue;
    logic                   hit;

    idrfl_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (slot_wdata),
        .rd_addr (slot_raddr),
        .rd_data (slot_rdata)
    );

    idrfl_ram #(
        .WIDTH (ID_W),
        .DEPTH (FREE_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    assign s_tready     = (state_reg == ST_IDLE);
    assign s_accept     = s_tvalid && s_tready;
    assign cfg_ready    = 1'b1;
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign cfg_start_wr = cfg_wr && (cfg_index == CFG_START_SIZE);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_id_reg);
    assign m_tuser  = m_ok_reg;

    // clamped register values
    always_comb begin
        if (lim_cfg_reg < SIZE_W'(LIM_MIN)) begin
            lim = SIZE_W'(LIM_MIN);
        end else if (lim_cfg_reg > SIZE_W'(MAX_ENTRIES)) begin
            lim = SIZE_W'(MAX_ENTRIES);
        end else begin
            lim = lim_cfg_reg;
        end

        if (fsz_cfg_reg < FSZ_W'(FSZ_MIN)) begin
            fs = FSZ_W'(FSZ_MIN);
        end else if (fsz_cfg_reg > FSZ_W'(FREE_DEPTH)) begin
            fs = FSZ_W'(FREE_DEPTH);
        end else begin
            fs = fsz_cfg_reg;
        end

        if (cfg_data[SIZE_W-1:0] == '0) begin
            start_val = SIZE_W'(1);
        end else if (cfg_data[SIZE_W-1:0] > SIZE_W'(MAX_ENTRIES)) begin
            start_val = SIZE_W'(MAX_ENTRIES);
        end else begin
            start_val = cfg_data[SIZE_W-1:0];
        end
    end

    // growth bound: used + GROW_STEP, capped at the limit
    assign grow_sum = SUM_W'(used_reg) + SUM_W'(GROW_STEP);
    assign grow_end = (grow_sum >= SUM_W'(lim)) ? lim : grow_sum[SIZE_W-1:0];

    assign fc_dec    = fc_reg - 1'b1;
    assign fc_inc1   = {1'b0, fc_reg} + 1'b1;
    assign push_room = (fc_reg < CNT_W'(FREE_DEPTH));
    assign addr_inc  = addr_reg + 1'b1;

    always_comb begin
        state_next      = state_reg;
        lim_cfg_next    = lim_cfg_reg;
        fsz_cfg_next    = fsz_cfg_reg;
        used_next       = used_reg;
        fc_next         = fc_reg;
        addr_next       = addr_reg;
        end_next        = end_reg;
        rd_vld_next     = rd_vld_reg;
        sweep_item_next = sweep_item_reg;
        handle_next     = handle_reg;
        eid_next        = eid_reg;
        rd_addr_next    = rd_addr_reg;
        res_id_next     = res_id_reg;
        res_ok_next     = res_ok_reg;
        m_id_next       = m_id_reg;
        m_ok_next       = m_ok_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        slot_we    = 1'b0;
        slot_waddr = addr_reg[ID_W-1:0];
        slot_wdata = '0;
        slot_raddr = addr_reg[ID_W-1:0];
        stk_we     = 1'b0;
        stk_waddr  = fc_reg[FIDX_W-1:0];
        stk_wdata  = rd_addr_reg;
        stk_raddr  = fc_dec[FIDX_W-1:0];
        issue      = 1'b0;
        hit        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    handle_next = s_tdata[HANDLE_BITS-1:0];
                    eid_next    = s_tdata[HANDLE_BITS+ID_W-1:HANDLE_BITS];
                    res_id_next = '0;
                    res_ok_next = 1'b0;
                    rd_vld_next = 1'b0;
                    addr_next   = SIZE_W'(1);
                    case (s_tuser)
                        MODE_REGISTER: begin
                            if (s_tdata[HANDLE_BITS-1:0] == '0) begin
                                state_next = ST_RESP;
                            end else if (fc_reg != '0) begin
                                state_next = ST_POP_RD;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        MODE_REMOVE_ID: begin
                            slot_raddr = s_tdata[HANDLE_BITS+ID_W-1:HANDLE_BITS];
                            state_next = ST_RID_CHK;
                        end
                        MODE_REMOVE_HANDLE: begin
                            if (s_tdata[HANDLE_BITS-1:0] == '0) begin
                                state_next = ST_RESP;
                            end else begin
                                state_next = ST_FIND;
                            end
                        end
                        default: begin
                            // clear: slots at or above used are already empty
                            fc_next         = '0;
                            addr_next       = '0;
                            end_next        = used_reg;
                            sweep_item_next = 1'b1;
                            res_ok_next     = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                    endcase
                end
            end

            ST_SWEEP: begin
                slot_we   = 1'b1;
                addr_next = addr_inc;
                if (addr_inc >= end_reg) begin
                    state_next = sweep_item_reg ? ST_RESP : ST_IDLE;
                end
            end

            ST_SCAN: begin
                // data for rd_addr_reg arrives while the next slot is read
                if (rd_vld_reg && (fc_reg < fs) && push_room && (slot_rdata == '0)) begin
                    hit       = 1'b1;
                    stk_we    = 1'b1;
                    stk_wdata = rd_addr_reg;
                    fc_next   = fc_inc1[CNT_W-1:0];
                end
                issue = (addr_reg < used_reg);
                if (issue) begin
                    rd_addr_next = addr_reg[ID_W-1:0];
                    addr_next    = addr_inc;
                end
                rd_vld_next = issue;
                if (!issue || (hit && (fc_inc1 >= fs))) begin
                    state_next = ST_GROW_CHK;
                end
            end

            ST_GROW_CHK: begin
                if ((fc_reg == '0) && (used_reg < lim)) begin
                    addr_next  = used_reg;
                    end_next   = grow_end;
                    state_next = ST_GROW;
                end else if (fc_reg != '0) begin
                    state_next = ST_POP_RD;
                end else begin
                    state_next = ST_RESP;
                end
            end

            ST_GROW: begin
                // new slots are already empty, only their ids go on the stack
                if ((addr_reg < end_reg) && (fc_reg < fs) && push_room) begin
                    stk_we    = 1'b1;
                    stk_wdata = addr_reg[ID_W-1:0];
                    fc_next   = fc_inc1[CNT_W-1:0];
                    addr_next = addr_inc;
                end else begin
                    used_next  = end_reg;
                    state_next = (fc_reg != '0) ? ST_POP_RD : ST_RESP;
                end
            end

            ST_POP_RD: begin
                fc_next    = fc_dec;
                state_next = ST_POP_WR;
            end

            ST_POP_WR: begin
                if (stk_rdata < used_reg) begin
                    slot_we     = 1'b1;
                    slot_waddr  = stk_rdata;
                    slot_wdata  = handle_reg;
                    res_id_next = stk_rdata;
                    res_ok_next = (stk_rdata != '0);
                end
                state_next = ST_RESP;
            end

            ST_RID_CHK: begin
                if ((eid_reg != '0) && (eid_reg < used_reg) && (slot_rdata != '0)) begin
                    slot_we     = 1'b1;
                    slot_waddr  = eid_reg;
                    res_id_next = eid_reg;
                    res_ok_next = 1'b1;
                    // push only while the stack stays below its size after the push
                    if (fc_inc1 < fs) begin
                        stk_we    = 1'b1;
                        stk_wdata = eid_reg;
                        fc_next   = fc_inc1[CNT_W-1:0];
                    end
                end
                state_next = ST_RESP;
            end

            ST_FIND: begin
                hit = rd_vld_reg && (slot_rdata == handle_reg);
                if (hit) begin
                    slot_we     = 1'b1;
                    slot_waddr  = rd_addr_reg;
                    res_id_next = rd_addr_reg;
                    res_ok_next = 1'b1;
                    if (fc_inc1 < fs) begin
                        stk_we    = 1'b1;
                        stk_wdata = rd_addr_reg;
                        fc_next   = fc_inc1[CNT_W-1:0];
                    end
                    state_next = ST_RESP;
                end else begin
                    issue = (addr_reg < used_reg);
                    if (issue) begin
                        rd_addr_next = addr_reg[ID_W-1:0];
                        addr_next    = addr_inc;
                    end else begin
                        state_next = ST_RESP;
                    end
                    rd_vld_next = issue;
                end
            end

            ST_RESP: begin
                // load the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_id_next    = res_id_reg;
                    m_ok_next    = res_ok_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration writes
        if (cfg_wr) begin
            unique case (cfg_index)
                CFG_ENTRY_LIMIT: begin
                    lim_cfg_next = cfg_data[SIZE_W-1:0];
                end
                CFG_FREE_LIST_SIZE: begin
                    fsz_cfg_next = cfg_data[FSZ_W-1:0];
                end
                CFG_START_SIZE: begin
                    // re-initialise: new size, empty stack, full clearing pass
                    used_next       = start_val;
                    fc_next         = '0;
                    addr_next       = '0;
                    end_next        = SIZE_W'(MAX_ENTRIES);
                    sweep_item_next = 1'b0;
                    state_next      = ST_SWEEP;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            lim_cfg_reg    <= SIZE_W'(RST_ENTRY_LIMIT);
            fsz_cfg_reg    <= FSZ_W'(RST_FREE_LIST_SIZE);
            used_reg       <= SIZE_W'(USED_RST);
            fc_reg         <= '0;
            addr_reg       <= '0;
            end_reg        <= SIZE_W'(MAX_ENTRIES);
            rd_vld_reg     <= 1'b0;
            sweep_item_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            lim_cfg_reg    <= lim_cfg_next;
            fsz_cfg_reg    <= fsz_cfg_next;
            used_reg       <= used_next;
            fc_reg         <= fc_next;
            addr_reg       <= addr_next;
            end_reg        <= end_next;
            rd_vld_reg     <= rd_vld_next;
            sweep_item_reg <= sweep_item_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        handle_reg  <= handle_next;
        eid_reg     <= eid_next;
        rd_addr_reg <= rd_addr_next;
        res_id_reg  <= res_id_next;
        res_ok_reg  <= res_ok_next;
        m_id_reg    <= m_id_next;
        m_ok_reg    <= m_ok_next;
    end

    // a pop read not cut short by a start_size write takes exactly one id off and moves on to the slot write
    `IDRFL_ASSERT_NXT(a_pop_dec, aclk, aresetn,
        (state_reg == ST_POP_RD) && !cfg_start_wr,
        (state_reg == ST_POP_WR) && (fc_reg == $past(fc_reg) - 1'b1),
        "pop did not take one id off the stack")

    // used size moves only at the end of a growth step or on a start_size write
    `IDRFL_ASSERT_IMP(a_used_src, aclk, aresetn,
        used_reg != $past(used_reg),
        ($past(state_reg) == ST_GROW) || $past(cfg_start_wr),
        "used size changed outside growth or re-init")

    // a new result only comes from the response state
    `IDRFL_ASSERT_IMP(a_result_src, aclk, aresetn,
        $rose(m_valid_reg),
        $past(state_reg) == ST_RESP,
        "result word raised outside the response state")

endmodule
